FILE: rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned PriW  = 16;
  localparam int unsigned ValW  = 32;
  localparam int unsigned OccW  = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                   mode;
    logic [PriW-1:0]        priority_req;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [PriW-1:0]        out_priority;
    logic signed [ValW-1:0] out_value;
    logic [1:0]             status;
    logic [OccW-1:0]        occupancy;
  } out_t;

  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [ValW-1:0] val;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  spq_pkg::entry_t     left_i,
  input  logic                left_go_i,
  input  spq_pkg::entry_t     right_i,
  output spq_pkg::entry_t     entry_o,
  output logic                go_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // go: the new item lands here or further left, so this cell moves
  assign go_o = !(occ_i && (entry_q.pri >= ctrl_i.item.pri));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && go_o) begin
      entry_d = left_go_i ? left_i : ctrl_i.item;
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue, highest priority at the head, DEPTH pairs.
// Input channel (in_valid_i/in_ready_o/in_data_i): mode 0 inserts
// (priority_req, value) behind every stored pair of equal or higher
// priority; mode 1 removes the head pair.
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one item per
// input item, carrying the removed pair (zero on insert), a status code
// (ok, remove from empty, insert into full dropped) and the occupancy.
// Results are registered; out_valid_o rises in the cycle after acceptance.
// Throughput: one item per cycle while not stalled; every cell compares its
// priority with the new one and shifts left, right or holds in that cycle.
// Reset clears the count and the output valid flag only; cell contents and
// the output data are left as they are, since no cell at or above the count
// is ever read and the output data is only looked at while valid.
// When the receiver stalls, the result waits in the output register and
// in_ready_o falls until it is taken.
module sorted_priority_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_data_o
);

  localparam logic [spq_pkg::CntW-1:0] DepthC = spq_pkg::CntW'(spq_pkg::DEPTH);

  logic [spq_pkg::CntW-1:0] count_q, count_d;
  logic                     out_valid_q;
  spq_pkg::out_t            out_q, out_d;
  spq_pkg::cell_ctrl_t      ctrl;
  spq_pkg::entry_t          entries [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] go;
  logic                     fire, ins_ok, rem_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign ins_ok = fire && (in_data_i.mode == spq_pkg::MODE_INSERT) && (count_q != DepthC);
  assign rem_ok = fire && (in_data_i.mode == spq_pkg::MODE_REMOVE) && (count_q != '0);

  assign ctrl.ins      = ins_ok;
  assign ctrl.rem      = rem_ok;
  assign ctrl.item.pri = in_data_i.priority_req;
  assign ctrl.item.val = in_data_i.value;

  for (genvar k = 0; k < spq_pkg::DEPTH; k++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_go;
    if (k == 0) begin : g_first
      assign left    = '0;
      assign left_go = 1'b0;
    end else begin : g_mid
      assign left    = entries[k-1];
      assign left_go = go[k-1];
    end
    if (k == spq_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entries[k+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (spq_pkg::CntW'(k) < count_q),
      .left_i    (left),
      .left_go_i (left_go),
      .right_i   (right),
      .entry_o   (entries[k]),
      .go_o      (go[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + 1'b1;
    end else if (rem_ok) begin
      count_d = count_q - 1'b1;
    end
    out_d              = '0;
    out_d.status       = spq_pkg::ST_OK;
    out_d.occupancy    = spq_pkg::OccW'(count_d);
    if (in_data_i.mode == spq_pkg::MODE_REMOVE) begin
      if (rem_ok) begin
        out_d.out_priority = entries[0].pri;
        out_d.out_value    = entries[0].val;
      end else begin
        out_d.status = spq_pkg::ST_EMPTY;
      end
    end else if (!ins_ok) begin
      out_d.status = spq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("count above depth");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= spq_pkg::CntW'(2)) |-> (entries[0].pri >= entries[1].pri))
    else $error("head not highest priority");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_data_i.mode == spq_pkg::MODE_REMOVE) && (count_q == '0))
    |=> (out_valid_o && (out_data_o.status == spq_pkg::ST_EMPTY)))
    else $error("empty remove not flagged");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_data_i.mode == spq_pkg::MODE_INSERT) && (count_q == DepthC))
    |=> (out_valid_o && (out_data_o.status == spq_pkg::ST_FULL) && $stable(count_q)))
    else $error("full insert not dropped");
`endif

endmodule

FILE: verif/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  spq_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  spq_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  spq_pkg::entry_t shadow [spq_pkg::DEPTH];
  int              shadow_fill;
  spq_pkg::out_t   expected_results [$];
  spq_pkg::out_t   want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fail_count_o < 50) begin
      $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, exp_val);
    end
    fail_count_o++;
  endtask

  // Sorted insert behind equal or higher priorities; remove takes the head.
  function automatic spq_pkg::out_t apply_item(input spq_pkg::in_t d);
    spq_pkg::out_t r;
    int            pos;
    int            i;
    r = '0;
    if (d.mode == spq_pkg::MODE_INSERT) begin
      if (shadow_fill >= int'(spq_pkg::DEPTH)) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_fill && shadow[pos].pri >= d.priority_req) pos++;
        for (i = shadow_fill; i > pos; i--) shadow[i] = shadow[i-1];
        shadow[pos].pri = d.priority_req;
        shadow[pos].val = d.value;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.out_priority = shadow[0].pri;
      r.out_value    = shadow[0].val;
      for (i = 1; i < shadow_fill; i++) shadow[i-1] = shadow[i];
      shadow_fill--;
    end
    r.occupancy = spq_pkg::OccW'(shadow_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data_i.occupancy), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(out_data_i.out_priority),
                            32'(want.out_priority));
          if (out_data_i.out_value !== want.out_value)
            report_mismatch("out_value", out_data_i.out_value, want.out_value);
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
          if (out_data_i.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_data_i.occupancy),
                            32'(want.occupancy));
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(apply_item(in_data_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NumRandom = 1850;
  localparam int QuietTail = 200;
  localparam int LongHold  = 60;
  localparam int IdleLimit = 1000;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  spq_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  spq_pkg::out_t out_data;
  int            fail_count;
  int            pending;

  int   hold_reqs = 0;
  bit   quiet     = 1'b0;
  int   idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_priority_queue_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  spq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic spq_pkg::in_t mk_item(input logic mode,
                                           input logic [spq_pkg::PriW-1:0] pri,
                                           input logic [spq_pkg::ValW-1:0] val);
    spq_pkg::in_t d;
    d.mode         = mode;
    d.priority_req = pri;
    d.value        = val;
    return d;
  endfunction

  // Narrow priorities give plenty of ties.
  function automatic spq_pkg::in_t rand_item(input int insert_pct);
    logic [spq_pkg::PriW-1:0] pri;
    int                       pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      pri = spq_pkg::PriW'($urandom_range(0, 7));
    else if (pick < 85) pri = spq_pkg::PriW'($urandom);
    else if (pick < 93) pri = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else                pri = spq_pkg::PriW'(1) << $urandom_range(0, spq_pkg::PriW - 1);
    return mk_item(($urandom_range(0, 99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                        : spq_pkg::MODE_REMOVE,
                   pri, $urandom);
  endfunction

  task automatic send(input spq_pkg::in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver
  initial begin
    int stall;
    int busy;
    int hold_seen;
    stall     = 0;
    busy      = 0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        stall     = LongHold;
        busy      = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (busy > 0 || quiet) begin
        if (busy > 0) busy--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        busy = $urandom_range(1, 20) - 1;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int sent;
    int seg_left;
    int insert_pct;
    sent     = 0;
    seg_left = 0;
    insert_pct = 50;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty remove, extremes, ties at head and tail, fill to full, overflow
    send(mk_item(spq_pkg::MODE_REMOVE, '0, '0));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hFFFF, 32'h7FFF_FFFF));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0000, 32'h8000_0000));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0000, 32'h0000_0001));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h8000, 32'h0000_0000));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0001, 32'h5555_5555));
    send(mk_item(spq_pkg::MODE_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h7FFF, 32'hAAAA_AAAA));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0000, 32'h0000_0002));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hFFFF, 32'h1234_5678));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h5555, 32'hDEAD_BEEF));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hAAAA, 32'h0F0F_0F0F));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0003, 32'hF0F0_F0F0));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0003, 32'h0000_0003));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0003, 32'h0000_0004));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h1234, 32'h8000_0001));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hFFFE, 32'h7FFF_FFFE));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0001, 32'h0000_0005));
    send(mk_item(spq_pkg::MODE_INSERT, 16'h0000, 32'h0000_0006));
    send(mk_item(spq_pkg::MODE_INSERT, 16'hFFFF, 32'hCAFE_F00D));
    send(mk_item(spq_pkg::MODE_REMOVE, '0, '0));
    send(mk_item(spq_pkg::MODE_REMOVE, '1, '1));
    send(mk_item(spq_pkg::MODE_REMOVE, '0, '0));

    while (sent < NumRandom) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 80);
        case ($urandom_range(0, 4))
          0:       insert_pct = 90;
          1:       insert_pct = 60;
          2:       insert_pct = 50;
          3:       insert_pct = 30;
          default: insert_pct = 10;
        endcase
      end
      if (sent == 300 || sent == 900) hold_reqs++;
      if (sent == 600 || sent == 1200) drain();
      if (sent == NumRandom - QuietTail) quiet = 1'b1;
      send(rand_item(insert_pct));
      sent++;
      seg_left--;
      if (!quiet && $urandom_range(0, 4) == 0) idle($urandom_range(1, 10));
    end

    drain();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sorted_priority_queue_unit.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
verif/spq_checker.sv
verif/tb.sv
